/* sv/multi_species_life_cell_update_macros.svh */
// ----------------------------------------------------------------------------
// multi_species_life_cell_update assertion macros
// Concurrent check wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef MULTI_SPECIES_LIFE_CELL_UPDATE_MACROS_SVH
`define MULTI_SPECIES_LIFE_CELL_UPDATE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MSLCU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("multi_species_life_cell_update: check failed");

// next-cycle implication
`define MSLCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("multi_species_life_cell_update: check failed");

`else

`define MSLCU_ASSERT_NOW(label, clk, rst, ante, cons)
`define MSLCU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/mslcu_pkg.sv */
// ----------------------------------------------------------------------------
// mslcu_pkg
// Shared widths, hash constants and stage status type of the cell update.
// ----------------------------------------------------------------------------
`default_nettype none

package mslcu_pkg;

   localparam int CELL_W   = 4;    // cell / species code
   localparam int NBR_N    = 8;    // neighbours per cell
   localparam int CNT_W    = 4;    // per-species count, 0..8
   localparam int COORD_W  = 12;   // cell_x / cell_y field width
   localparam int SEED_W   = 32;
   localparam int HASH_W   = 32;
   localparam int REQ_W    = 96;   // 92 payload bits padded to bytes
   localparam int RSP_W    = 8;

   localparam int SPECIES_MAX_DEF = 10;
   localparam int COORD_BITS_DEF  = 12;

   localparam logic [CELL_W-1:0] SPECIES_RESET = 4'd10;

   localparam logic [HASH_W-1:0] HASH_X  = 32'd73856093;
   localparam logic [HASH_W-1:0] HASH_Y  = 32'd19349663;
   localparam logic [HASH_W-1:0] LCG_MUL = 32'd1103515245;
   localparam logic [HASH_W-1:0] LCG_ADD = 32'd12345;

   // centre-cell verdict carried down the pipe
   typedef struct packed {
      logic              alive;    // centre code non-zero
      logic              survive;  // valid species with 2 or 3 of its own
      logic [CELL_W-1:0] centre;
   } cell_stat_type;

endpackage

`default_nettype wire

/* sv/mslcu_count.sv */
// ----------------------------------------------------------------------------
// mslcu_count
// Stage 1: per-species neighbour counts, survival test, birth candidates,
// coordinate hash products.
// ----------------------------------------------------------------------------
`default_nettype none

module mslcu_count
   import mslcu_pkg::*;
#(
   parameter int MAX_SPECIES = SPECIES_MAX_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  logic [CELL_W-1:0]         species_in_use,
   input  logic [CELL_W-1:0]         centre,
   input  logic [NBR_N*CELL_W-1:0]   nbrs,
   input  logic [COORD_W-1:0]        cell_x,
   input  logic [COORD_W-1:0]        cell_y,
   input  logic [SEED_W-1:0]         seed,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output cell_stat_type             dn_stat,
   output logic [MAX_SPECIES-1:0]    dn_mask,
   output logic [HASH_W-1:0]         dn_px,
   output logic [HASH_W-1:0]         dn_py,
   output logic [SEED_W-1:0]         dn_seed
);

   logic [CNT_W-1:0]       cnt [MAX_SPECIES];
   logic [COORD_W-1:0]     x_m, y_m;
   cell_stat_type          stat_in, stat_ff;
   logic [MAX_SPECIES-1:0] mask_in, mask_ff;
   logic [HASH_W-1:0]      px_in, py_in, px_ff, py_ff;
   logic [SEED_W-1:0]      seed_ff;
   logic                   valid_ff;

   always_comb begin
      stat_in.alive   = (centre != '0);
      stat_in.centre  = centre;
      stat_in.survive = 1'b0;
      for (int s = 0; s < MAX_SPECIES; s++) begin
         cnt[s] = '0;
         for (int n = 0; n < NBR_N; n++) begin
            if (nbrs[n*CELL_W +: CELL_W] == CELL_W'(s + 1)) begin
               cnt[s] = cnt[s] + CNT_W'(1);
            end
         end
         if (centre == CELL_W'(s + 1) &&
             (cnt[s] == CNT_W'(2) || cnt[s] == CNT_W'(3))) begin
            stat_in.survive = 1'b1;
         end
         mask_in[s] = (cnt[s] == CNT_W'(3)) && (CELL_W'(s + 1) <= species_in_use);
      end
   end

   // only the low COORD_BITS of each coordinate enter the hash
   always_comb begin
      for (int i = 0; i < COORD_W; i++) begin
         x_m[i] = (i < COORD_BITS) ? cell_x[i] : 1'b0;
         y_m[i] = (i < COORD_BITS) ? cell_y[i] : 1'b0;
      end
   end

   assign px_in = {{(HASH_W-COORD_W){1'b0}}, x_m} * HASH_X;
   assign py_in = {{(HASH_W-COORD_W){1'b0}}, y_m} * HASH_Y;

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         stat_ff <= stat_in;
         mask_ff <= mask_in;
         px_ff   <= px_in;
         py_ff   <= py_in;
         seed_ff <= seed;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_stat  = stat_ff;
   assign dn_mask  = mask_ff;
   assign dn_px    = px_ff;
   assign dn_py    = py_ff;
   assign dn_seed  = seed_ff;

endmodule

`default_nettype wire

/* sv/mslcu_hash.sv */
// ----------------------------------------------------------------------------
// mslcu_hash
// Stage 2: fold hash products with the seed, LCG multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module mslcu_hash
   import mslcu_pkg::*;
#(
   parameter int MAX_SPECIES = SPECIES_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  cell_stat_type          up_stat,
   input  logic [MAX_SPECIES-1:0] up_mask,
   input  logic [HASH_W-1:0]      up_px,
   input  logic [HASH_W-1:0]      up_py,
   input  logic [SEED_W-1:0]      up_seed,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output cell_stat_type          dn_stat,
   output logic [MAX_SPECIES-1:0] dn_mask,
   output logic [HASH_W-1:0]      dn_prod
);

   logic [HASH_W-1:0]      h_mix;
   logic [HASH_W-1:0]      prod_in, prod_ff;
   cell_stat_type          stat_ff;
   logic [MAX_SPECIES-1:0] mask_ff;
   logic                   valid_ff;

   assign h_mix   = up_px ^ up_py ^ up_seed;
   assign prod_in = LCG_MUL * h_mix;   // low 32 bits only

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         stat_ff <= up_stat;
         mask_ff <= up_mask;
         prod_ff <= prod_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_stat  = stat_ff;
   assign dn_mask  = mask_ff;
   assign dn_prod  = prod_ff;

endmodule

`default_nettype wire

/* sv/mslcu_pick.sv */
// ----------------------------------------------------------------------------
// mslcu_pick
// Stage 3: finish LCG, choose birth species, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mslcu_pick
   import mslcu_pkg::*;
#(
   parameter int MAX_SPECIES = SPECIES_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  cell_stat_type          up_stat,
   input  logic [MAX_SPECIES-1:0] up_mask,
   input  logic [HASH_W-1:0]      up_prod,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output logic [CELL_W-1:0]      dn_next
);

   logic [HASH_W-1:0] h_fin;
   logic [CELL_W-1:0] lo_sp, hi_sp;
   logic [CELL_W-1:0] next_in, next_ff;
   logic              valid_ff;

   assign h_fin = up_prod + LCG_ADD;

   // Eight neighbours hold at most two species with three each, so the
   // candidate list is {lo} or {lo, hi}; h mod 2 is the low hash bit.
   always_comb begin
      lo_sp = '0;
      hi_sp = '0;
      for (int s = MAX_SPECIES - 1; s >= 0; s--) begin
         if (up_mask[s]) begin
            lo_sp = CELL_W'(s + 1);
         end
      end
      for (int s = 0; s < MAX_SPECIES; s++) begin
         if (up_mask[s]) begin
            hi_sp = CELL_W'(s + 1);
         end
      end
   end

   always_comb begin
      if (up_stat.alive) begin
         next_in = up_stat.survive ? up_stat.centre : '0;
      end else if (lo_sp != hi_sp && h_fin[0]) begin
         next_in = hi_sp;
      end else begin
         next_in = lo_sp;   // zero when no candidate
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         next_ff <= next_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_next  = next_ff;

endmodule

`default_nettype wire

/* sv/multi_species_life_cell_update.sv */
// ----------------------------------------------------------------------------
// multi_species_life_cell_update
// Next-state rule of a multi-species Life cell, three-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | ports                            | beat
//  ---------+----------------------------------+---------------------------
//  request  | req_tvalid/req_tready/req_tdata  | one cell + neighbours
//  response | rsp_tvalid/rsp_tready/rsp_tdata  | next state of that cell
//  control  | csr_wr_en/csr_wr_data            | species_in_use write
//
//  One beat in per clock unless stalled; stages: count, hash mix, pick.
//  Each stage holds one beat with its own valid bit; a stage accepts when
//  empty or when the stage below takes its beat, so bubbles close up and
//  a rsp_tready stall backs up without dropping or repeating a beat.
//  One beat per clock is sustained while rsp_tready holds high; the 32x32
//  LCG multiply in stage two sets the clock period.
//  reset (synchronous) empties the pipe and sets species_in_use to 10.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_species_life_cell_update_macros.svh"

module multi_species_life_cell_update
   import mslcu_pkg::*;
#(
   parameter int MAX_SPECIES = SPECIES_MAX_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [3:0] centre_cell, [7:4] nbr_up_left, [11:8] nbr_up,
   // [15:12] nbr_up_right, [19:16] nbr_left, [23:20] nbr_right,
   // [27:24] nbr_down_left, [31:28] nbr_down, [35:32] nbr_down_right,
   // [47:36] cell_x, [59:48] cell_y, [91:60] frame_seed_value, rest zero
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [3:0] next_cell, rest zero
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_wr_en,
   input  logic [CELL_W-1:0] csr_wr_data
);

   // field offsets in req_tdata
   localparam int NBR_LSB  = CELL_W;
   localparam int X_LSB    = CELL_W + NBR_N*CELL_W;
   localparam int Y_LSB    = X_LSB + COORD_W;
   localparam int SEED_LSB = Y_LSB + COORD_W;

   logic [CELL_W-1:0] species_ff, species_in;

   // stage 1 -> 2
   logic                   s1_valid, s2_ready;
   cell_stat_type          s1_stat;
   logic [MAX_SPECIES-1:0] s1_mask;
   logic [HASH_W-1:0]      s1_px, s1_py;
   logic [SEED_W-1:0]      s1_seed;
   // stage 2 -> 3
   logic                   s2_valid, s3_ready;
   cell_stat_type          s2_stat;
   logic [MAX_SPECIES-1:0] s2_mask;
   logic [HASH_W-1:0]      s2_prod;
   logic [CELL_W-1:0]      next_cell;

   // species count register; the user must write it only while the pipe is idle, the block does not enforce this
   assign species_in = csr_wr_en ? csr_wr_data : species_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         species_ff <= SPECIES_RESET;
      end else begin
         species_ff <= species_in;
      end
   end

   // stage 1: neighbour counts, survive/birth flags, coordinate products
   mslcu_count #(
      .MAX_SPECIES (MAX_SPECIES),
      .COORD_BITS  (COORD_BITS)
   ) u_count (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (req_tvalid),
      .up_ready       (req_tready),
      .species_in_use (species_ff),
      .centre         (req_tdata[CELL_W-1:0]),
      .nbrs           (req_tdata[NBR_LSB +: NBR_N*CELL_W]),
      .cell_x         (req_tdata[X_LSB +: COORD_W]),
      .cell_y         (req_tdata[Y_LSB +: COORD_W]),
      .seed           (req_tdata[SEED_LSB +: SEED_W]),
      .dn_valid       (s1_valid),
      .dn_ready       (s2_ready),
      .dn_stat        (s1_stat),
      .dn_mask        (s1_mask),
      .dn_px          (s1_px),
      .dn_py          (s1_py),
      .dn_seed        (s1_seed)
   );

   // stage 2: hash fold and LCG multiply
   mslcu_hash #(
      .MAX_SPECIES (MAX_SPECIES)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s1_valid),
      .up_ready (s2_ready),
      .up_stat  (s1_stat),
      .up_mask  (s1_mask),
      .up_px    (s1_px),
      .up_py    (s1_py),
      .up_seed  (s1_seed),
      .dn_valid (s2_valid),
      .dn_ready (s3_ready),
      .dn_stat  (s2_stat),
      .dn_mask  (s2_mask),
      .dn_prod  (s2_prod)
   );

   // stage 3: tie-break, final state; its register drives the response
   mslcu_pick #(
      .MAX_SPECIES (MAX_SPECIES)
   ) u_pick (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_ready (s3_ready),
      .up_stat  (s2_stat),
      .up_mask  (s2_mask),
      .up_prod  (s2_prod),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_next  (next_cell)
   );

   assign rsp_tdata = {{(RSP_W-CELL_W){1'b0}}, next_cell};

   // ---- checks ----
   // at most two species can have three neighbours each
   `MSLCU_ASSERT_NOW(a_two_cand, clock, reset, s2_valid, $countones(s2_mask) <= 2)
   // a result never names a species beyond the configured maximum
   `MSLCU_ASSERT_NOW(a_next_range, clock, reset, rsp_tvalid,
      rsp_tdata[CELL_W-1:0] <= CELL_W'(MAX_SPECIES))
   // a full pipe with a stalled response takes no new beat
   `MSLCU_ASSERT_NOW(a_full_stall, clock, reset,
      s1_valid && s2_valid && rsp_tvalid && !rsp_tready, !req_tready)
   // the response register drains when taken and nothing arrives behind it
   `MSLCU_ASSERT_NEXT(a_drain, clock, reset,
      rsp_tvalid && rsp_tready && !s2_valid, !rsp_tvalid)

endmodule

`default_nettype wire

/* tb/sv/tb_multi_species_life_cell_update.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_species_life_cell_update
// Self-checking bench for the multi-species Life cell update. Directed cells
// cover survival, births, hash tie-breaks and out-of-range species codes.
// Random cells then sweep every species_in_use setting, with bursty requests
// and a stalling response side. A local predictor checks each response beat.
// ----------------------------------------------------------------------------
module tb_multi_species_life_cell_update;
   import mslcu_pkg::*;

   // request beat layout
   localparam int NBR_LSB   = CELL_W;              // eight neighbour nibbles
   localparam int X_LSB     = 36;
   localparam int Y_LSB     = 48;
   localparam int SEED_LSB  = 60;
   localparam int PIPE_TAIL = 6;                   // settle time after the last response

   // species_in_use sweep for the random part, entry 0 in the low nibble:
   // 10 1 2 .. 9 0 15 11 12 13 14 10
   localparam int SWEEP_N = 17;
   localparam logic [SWEEP_N-1:0][CELL_W-1:0] LIMIT_SWEEP = 68'hAEDCBF0987654321A;
   localparam int RANDOM_CELLS_PER_SETTING = 82;

   // neighbour set, [0] = up-left ... [7] = down-right
   typedef logic [NBR_N-1:0][CELL_W-1:0] nbr_set_type;

   // response-side pacing
   typedef enum int {PACE_OPEN, PACE_TOGGLE, PACE_RANDOM, PACE_HOLD} rsp_pace_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_wr_en;
   logic [CELL_W-1:0] csr_wr_data;

   // bench-side copy of the register
   logic [CELL_W-1:0] species_limit_shadow = SPECIES_RESET;
   logic [15:0]       limits_seen = '0;

   logic [CELL_W-1:0] pending_next_cells[$];
   int                burst_left    = 0;
   int                fail_count    = 0;
   int                cells_checked = 0;
   int                cells_sent    = 0;
   int                births_seen   = 0;
   int                hash_births   = 0;

   multi_species_life_cell_update DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Next-state predictor: per-species neighbour counts, B3/S23 per species,
   // births limited to species 1..min(limit,10), hash pick on a double birth.
   // ------------------------------------------------------------------------
   function automatic logic [CELL_W-1:0] predict_next_cell(
         input logic [REQ_W-1:0] beat, input logic [CELL_W-1:0] limit_reg,
         output bit by_hash);
      int                own [SPECIES_MAX_DEF+1];
      logic [CELL_W-1:0] cand [SPECIES_MAX_DEF];
      logic [CELL_W-1:0] centre;
      logic [CELL_W-1:0] code;
      logic [CELL_W-1:0] lim;
      logic [HASH_W-1:0] mix;
      int                ncand;
      centre  = beat[CELL_W-1:0];
      by_hash = 1'b0;
      ncand   = 0;
      for (int s = 0; s <= SPECIES_MAX_DEF; s++) own[s] = 0;
      // codes above the species range are not counted
      for (int n = 0; n < NBR_N; n++) begin
         code = beat[NBR_LSB + n*CELL_W +: CELL_W];
         if (code != 0 && code <= SPECIES_MAX_DEF) own[code]++;
      end
      // live cell: survives on 2 or 3 of its own kind; foreign codes die
      if (centre != 0)
         return (centre <= SPECIES_MAX_DEF && (own[centre] == 2 || own[centre] == 3)) ?
                centre : '0;
      // dead cell: limit saturates at the species maximum
      lim = (limit_reg > SPECIES_MAX_DEF) ? CELL_W'(SPECIES_MAX_DEF) : limit_reg;
      for (int s = 1; s <= SPECIES_MAX_DEF; s++)
         if (s <= lim && own[s] == 3) begin
            cand[ncand] = CELL_W'(s);
            ncand++;
         end
      if (ncand == 0) return '0;
      if (ncand == 1) return cand[0];
      by_hash = 1'b1;
      mix = (HASH_W'(beat[X_LSB +: COORD_W]) * HASH_X) ^
            (HASH_W'(beat[Y_LSB +: COORD_W]) * HASH_Y) ^ beat[SEED_LSB +: SEED_W];
      mix = LCG_MUL * mix + LCG_ADD;
      return cand[mix % HASH_W'(ncand)];
   endfunction

   function automatic logic [REQ_W-1:0] pack_cell(
         input logic [CELL_W-1:0] centre, input nbr_set_type nbr,
         input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
         input logic [SEED_W-1:0] seed);
      logic [REQ_W-1:0] beat;
      beat = '0;
      beat[CELL_W-1:0]                 = centre;
      beat[NBR_LSB +: NBR_N*CELL_W]    = nbr;
      beat[X_LSB +: COORD_W]           = x;
      beat[Y_LSB +: COORD_W]           = y;
      beat[SEED_LSB +: SEED_W]         = seed;
      return beat;
   endfunction

   // Mostly well-formed neighbourhoods (double births, single births, live
   // cells near 2/3), plus raw noise and foreign species codes.
   function automatic logic [REQ_W-1:0] random_cell();
      nbr_set_type       nbr;
      logic [CELL_W-1:0] centre;
      logic [CELL_W-1:0] sp_a;
      logic [CELL_W-1:0] sp_b;
      logic [CELL_W-1:0] tmp;
      int                roll;
      int                k;
      int                j;
      roll = $urandom_range(0, 99);
      sp_a = CELL_W'($urandom_range(1, SPECIES_MAX_DEF));
      sp_b = CELL_W'(1 + (sp_a - 1 + $urandom_range(1, SPECIES_MAX_DEF - 1)) % SPECIES_MAX_DEF);
      for (int i = 0; i < NBR_N; i++)
         nbr[i] = ($urandom_range(0, 1) == 0) ? '0 : CELL_W'($urandom_range(0, 15));
      centre = '0;
      if (roll < 30) begin
         for (int i = 0; i < 3; i++) begin
            nbr[i]     = sp_a;
            nbr[i + 3] = sp_b;
         end
      end else if (roll < 50) begin
         for (int i = 0; i < 3; i++) nbr[i] = sp_a;
      end else if (roll < 80) begin
         centre = sp_a;
         k = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 3) : $urandom_range(0, NBR_N);
         for (int i = 0; i < k; i++) nbr[i] = sp_a;
      end else if (roll < 92) begin
         centre = CELL_W'($urandom_range(0, 15));
         for (int i = 0; i < NBR_N; i++) nbr[i] = CELL_W'($urandom_range(0, 15));
      end else begin
         // foreign codes in a birth-like pattern
         tmp    = CELL_W'($urandom_range(SPECIES_MAX_DEF + 1, 15));
         centre = ($urandom_range(0, 1) == 0) ? '0 : tmp;
         for (int i = 0; i < 3; i++) nbr[i] = tmp;
      end
      for (int i = NBR_N - 1; i > 0; i--) begin
         j      = $urandom_range(0, i);
         tmp    = nbr[i];
         nbr[i] = nbr[j];
         nbr[j] = tmp;
      end
      return pack_cell(centre, nbr, COORD_W'($urandom_range(0, 4095)),
                       COORD_W'($urandom_range(0, 4095)), SEED_W'($urandom));
   endfunction

   // ------------------------------------------------------------------------
   // Request side: bursts of random length, random gaps between them.
   // tvalid stays high across back-to-back beats of a burst.
   // ------------------------------------------------------------------------
   task automatic send_cell(input logic [REQ_W-1:0] beat);
      int                gap;
      bit                by_hash;
      logic [CELL_W-1:0] next_cell;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      next_cell = predict_next_cell(beat, species_limit_shadow, by_hash);
      pending_next_cells.push_back(next_cell);
      cells_sent++;
      if (beat[CELL_W-1:0] == 0 && next_cell != 0) births_seen++;
      if (by_hash) hash_births++;
   endtask

   // drop tvalid, let every response come back, then the pipe tail
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_next_cells.size() != 0);
      repeat (PIPE_TAIL) @(posedge clock);
   endtask

   task automatic write_species_limit(input logic [CELL_W-1:0] limit_val);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit_val;
      @(posedge clock);
      species_limit_shadow = limit_val;
      limits_seen[limit_val] = 1'b1;
      csr_wr_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response side: segments of open flow, toggling, random, and hard stalls.
   // ------------------------------------------------------------------------
   initial begin : rsp_stall_pattern
      rsp_pace_type pace;
      int           run;
      rsp_tready <= 1'b0;
      forever begin
         pace = rsp_pace_type'($urandom_range(0, 3));
         run  = (pace == PACE_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
         repeat (run) begin
            @(posedge clock);
            case (pace)
               PACE_OPEN:   rsp_tready <= 1'b1;
               PACE_TOGGLE: rsp_tready <= ~rsp_tready;
               PACE_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
               default:     rsp_tready <= 1'b0;
            endcase
         end
      end
   end

   // Response checker: every beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_next_cells.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response beat, tdata %h", rsp_tdata);
         end else begin
            logic [CELL_W-1:0] want;
            want = pending_next_cells.pop_front();
            if (rsp_tdata !== {{(RSP_W-CELL_W){1'b0}}, want}) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("cell %0d: next_cell expected %0d, got %0d (tdata %h)",
                           cells_checked, want, rsp_tdata[CELL_W-1:0], rsp_tdata);
            end
            cells_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Directed tests. Neighbour hex: low nibble up-left ... high nibble
   // down-right; A = species 10, B..F are out-of-range codes.
   // ------------------------------------------------------------------------
   task automatic test_survival();
      send_cell(pack_cell(4'd0,  32'h0000_0000, 12'd0,  12'd0,  32'h0));
      send_cell(pack_cell(4'd1,  32'h0000_0011, 12'd3,  12'd4,  32'h0));   // two own
      send_cell(pack_cell(4'd10, 32'h0A0A_0A00, 12'd5,  12'd6,  32'h1));   // three own
      send_cell(pack_cell(4'd5,  32'h0300_5002, 12'd7,  12'd8,  32'h2));   // one own
      send_cell(pack_cell(4'd7,  32'h7777_0000, 12'd9,  12'd10, 32'h3));   // crowded
      send_cell(pack_cell(4'd3,  32'h3333_3333, 12'd11, 12'd12, 32'h4));   // all eight
      send_cell(pack_cell(4'd6,  32'hC0C0_C066, 12'd13, 12'd14, 32'h5));   // foreign ignored
   endtask

   task automatic test_births();
      send_cell(pack_cell(4'd0, 32'h0004_0404, 12'd20, 12'd21, 32'h6));
      send_cell(pack_cell(4'd0, 32'hAAA0_0000, 12'd22, 12'd23, 32'h7));    // top species
      send_cell(pack_cell(4'd0, 32'h0000_1111, 12'd24, 12'd25, 32'h8));    // four, no birth
      // double births, hash decides; coordinate and seed extremes
      send_cell(pack_cell(4'd0, 32'h0099_9222, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF));
      send_cell(pack_cell(4'd0, 32'h00AA_A111, 12'h000, 12'h000, 32'h0000_0000));
      send_cell(pack_cell(4'd0, 32'h0088_8333, 12'hAAA, 12'h555, 32'h5555_AAAA));
      send_cell(pack_cell(4'd0, 32'h0066_6555, 12'h555, 12'hAAA, 32'hAAAA_5555));
   endtask

   task automatic test_foreign_codes();
      send_cell(pack_cell(4'd0,  32'hBBFF_FEDC, 12'd30, 12'd31, 32'h9));   // three 15s
      send_cell(pack_cell(4'd15, 32'h00FF_F000, 12'd32, 12'd33, 32'hA));
      send_cell(pack_cell(4'd11, 32'h0000_00BB, 12'd34, 12'd35, 32'hB));
      send_cell(pack_cell(4'd0,  32'hFFEE_E222, 12'd36, 12'd37, 32'hC));   // only 2 counts
   endtask

   task automatic test_species_limit();
      write_species_limit(4'd1);
      send_cell(pack_cell(4'd0, 32'h0000_0111, 12'd40, 12'd41, 32'hD));
      send_cell(pack_cell(4'd0, 32'h0000_0222, 12'd42, 12'd43, 32'hE));    // above limit
      send_cell(pack_cell(4'd0, 32'h0022_2111, 12'd44, 12'd45, 32'hF));    // only 1 counts
      send_cell(pack_cell(4'd2, 32'h0000_0022, 12'd46, 12'd47, 32'h10));   // survival unaffected
      write_species_limit(4'd0);                                          // no births at all
      send_cell(pack_cell(4'd0, 32'h0000_0111, 12'd48, 12'd49, 32'h11));
      send_cell(pack_cell(4'd4, 32'h0000_0444, 12'd50, 12'd51, 32'h12));
      write_species_limit(4'd15);                                         // saturates at 10
      send_cell(pack_cell(4'd0, 32'h0000_0AAA, 12'd52, 12'd53, 32'h13));
      send_cell(pack_cell(4'd0, 32'h00AA_A999, 12'd54, 12'd55, 32'h14));
   endtask

   task automatic test_random_sweep();
      for (int p = 0; p < SWEEP_N; p++) begin
         write_species_limit(LIMIT_SWEEP[p]);
         repeat (RANDOM_CELLS_PER_SETTING) send_cell(random_cell());
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of species_in_use (10) is in force for the first three
      test_survival();
      test_births();
      test_foreign_codes();
      test_species_limit();
      test_random_sweep();
      wait_idle();

      $display("%0d cells checked over %0d species_in_use settings",
               cells_checked, $countones(limits_seen));
      $display("%0d births, %0d of them settled by the coordinate hash",
               births_seen, hash_births);
      if (fail_count == 0 && pending_next_cells.size() == 0)
         $display("multi_species_life_cell_update regression: pass");
      else
         $display("multi_species_life_cell_update regression: fail");
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("multi_species_life_cell_update regression: fail");
      $finish;
   end

endmodule
